// File: rtl/hrta_pkg.sv
// ----------------------------------------------------------------------------
// hrta_pkg
// Shared types, constants and keycode tables for the boot report to ASCII
// converter.
// ----------------------------------------------------------------------------
package hrta_pkg;

    localparam int SLOTS     = 6;
    localparam int KEY_W     = 8;
    localparam int CHAR_W    = 7;
    localparam int TABLE_LEN = 57;

    localparam logic [KEY_W-1:0] SHIFT_MASK = 8'h22;

    // six keycodes of one report, slot 0 in the lowest byte
    typedef logic [SLOTS-1:0][KEY_W-1:0] t_key_set;

    // what one lane found for its slot
    typedef struct packed {
        logic              hit;
        logic [CHAR_W-1:0] chr;
    } t_lane_res;

    typedef logic [CHAR_W-1:0] t_char_tab [0:TABLE_LEN-1];

    // us layout, no shift
    localparam t_char_tab PLAIN_MAP = '{
        7'h00, 7'h00, 7'h00, 7'h00, 7'h61, 7'h62, 7'h63, 7'h64,
        7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6a, 7'h6b, 7'h6c,
        7'h6d, 7'h6e, 7'h6f, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74,
        7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a, 7'h31, 7'h32,
        7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h2d, 7'h3d, 7'h5b,
        7'h5d, 7'h5c, 7'h00, 7'h3b, 7'h27, 7'h60, 7'h2c, 7'h2e,
        7'h2f
    };

    // us layout, either shift held
    localparam t_char_tab SHIFT_MAP = '{
        7'h00, 7'h00, 7'h00, 7'h00, 7'h41, 7'h42, 7'h43, 7'h44,
        7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4a, 7'h4b, 7'h4c,
        7'h4d, 7'h4e, 7'h4f, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
        7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5a, 7'h21, 7'h40,
        7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
        7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h5f, 7'h2b, 7'h7b,
        7'h7d, 7'h7c, 7'h00, 7'h3a, 7'h22, 7'h7e, 7'h3c, 7'h3e,
        7'h3f
    };

    // keycode to character, zero for keys past the table
    function automatic logic [CHAR_W-1:0] ascii_lookup(input logic [KEY_W-1:0] kc,
                                                       input logic shifted);
        logic [CHAR_W-1:0] c;
        c = '0;
        if (kc < KEY_W'(TABLE_LEN)) begin
            c = shifted ? SHIFT_MAP[kc[5:0]] : PLAIN_MAP[kc[5:0]];
        end
        return c;
    endfunction

endpackage

// File: rtl/hrta_lane.sv
// ----------------------------------------------------------------------------
// hrta_lane
// One key slot: checks the keycode against the previous set of its keyboard
// and looks up its character.
// ----------------------------------------------------------------------------
module hrta_lane (
    input  logic [hrta_pkg::KEY_W-1:0] i_key,
    input  hrta_pkg::t_key_set         i_prev,
    input  logic                       i_shifted,
    output hrta_pkg::t_lane_res        o_res
);

    logic                        w_held;
    logic [hrta_pkg::CHAR_W-1:0] w_chr;

    // was this keycode down in the last report
    always_comb begin
        w_held = 1'b0;
        for (int j = 0; j < hrta_pkg::SLOTS; j++) begin
            if (i_prev[j] == i_key) begin
                w_held = 1'b1;
            end
        end
    end

    // table lookup, unmapped keys give zero
    assign w_chr = hrta_pkg::ascii_lookup(i_key, i_shifted);

    assign o_res.chr = w_chr;
    assign o_res.hit = (i_key != '0) && !w_held && (w_chr != '0);

endmodule

// File: rtl/hrta_key_store.sv
// ----------------------------------------------------------------------------
// hrta_key_store
// Previous key sets, one row of six keycodes per keyboard. Registered read
// with bypass of a write to the same row in the same cycle.
// ----------------------------------------------------------------------------
module hrta_key_store #(
    parameter int KEYBOARDS = 8,
    localparam int AW = (KEYBOARDS > 1) ? $clog2(KEYBOARDS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output hrta_pkg::t_key_set o_rd_keys,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  hrta_pkg::t_key_set i_wr_keys
);

    hrta_pkg::t_key_set r_mem [KEYBOARDS];
    logic [KEYBOARDS-1:0] r_row_vld;
    hrta_pkg::t_key_set   r_rd_data;
    logic                 r_rd_vld;
    logic                 r_byp;
    hrta_pkg::t_key_set   r_byp_data;

    // row storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_keys;
        end
    end

    // row valid bits, a row never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_addr] <= 1'b1;
        end
    end

    // registered read and bypass capture
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_keys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_byp    <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_row_vld[i_rd_addr];
            r_byp    <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_keys = r_byp    ? r_byp_data :
                       r_rd_vld ? r_rd_data  : '0;

endmodule

// File: rtl/hrta_merge.sv
// ----------------------------------------------------------------------------
// hrta_merge
// Collects the lane hits of one report and sends the characters out one word
// per cycle while the output is ready, in slot order, flagging the last one.
// ----------------------------------------------------------------------------
module hrta_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_load,
    input  hrta_pkg::t_lane_res [hrta_pkg::SLOTS-1:0] i_res,
    output logic                                    o_can_load,
    output logic                                    o_tvalid,
    input  logic                                    i_tready,
    output logic [hrta_pkg::CHAR_W-1:0]             o_chr,
    output logic                                    o_last
);

    logic [hrta_pkg::SLOTS-1:0]  r_mask, n_mask;
    logic [hrta_pkg::CHAR_W-1:0] r_chr [hrta_pkg::SLOTS];
    logic [hrta_pkg::SLOTS-1:0]  w_low;
    logic                        w_take;

    // lowest pending slot
    assign w_low = r_mask & (~r_mask + hrta_pkg::SLOTS'(1));

    always_comb begin
        o_chr = '0;
        for (int i = 0; i < hrta_pkg::SLOTS; i++) begin
            if (w_low[i]) begin
                o_chr = r_chr[i];
            end
        end
    end

    assign o_tvalid   = (r_mask != '0);
    assign o_last     = ((r_mask & ~w_low) == '0);
    assign w_take     = o_tvalid && i_tready;
    assign o_can_load = !o_tvalid || (w_take && o_last);

    // pending mask update
    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            for (int i = 0; i < hrta_pkg::SLOTS; i++) begin
                n_mask[i] = i_res[i].hit;
            end
        end else if (w_take) begin
            n_mask = r_mask & ~w_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    // characters of the report in flight
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < hrta_pkg::SLOTS; i++) begin
                r_chr[i] <= i_res[i].chr;
            end
        end
    end

endmodule

// File: rtl/hid_boot_report_to_ascii.sv
// ----------------------------------------------------------------------------
// hid_boot_report_to_ascii
// Boot protocol keyboard reports in, ASCII characters of newly pressed keys
// out, with a separate previous key set per keyboard.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                            | side band
//  --------+-----+----------------------------------+------------------------
//  s       | in  | modifier_bits, key_slot_0..5     | tuser keyboard_index
//  m       | out | ascii_char (7 bits, zero padded) | tlast last_of_report
//
//  A report is read from the key store at acceptance and checked by six lanes
//  the cycle after; its characters leave one per cycle from the merge stage
//  while the output is ready.
//  A new report is taken each cycle while the merge stage can load; a report
//  with no characters never waits on the output side.
//  Synchronous active-low reset clears all stored key sets at once.
// ----------------------------------------------------------------------------
module hid_boot_report_to_ascii #(
    parameter int KEYBOARDS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // modifier_bits, key_slot_0 .. key_slot_5
    input  logic [2:0]  i_s_tuser,   // keyboard_index
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // ascii_char, one zero bit
    output logic        o_m_tlast    // last_of_report
);

    localparam int AW = (KEYBOARDS > 1) ? $clog2(KEYBOARDS) : 1;

    logic [AW+2:0]          w_kb_ext;
    logic                   w_accept;
    logic                   w_s1_adv;
    logic                   w_any_hit;
    logic                   w_can_load;
    logic                   w_load;
    logic [6:0]             w_chr;
    hrta_pkg::t_key_set     w_in_keys;
    hrta_pkg::t_key_set     w_prev;
    hrta_pkg::t_lane_res [hrta_pkg::SLOTS-1:0] w_res;
    hrta_pkg::t_lane_res [hrta_pkg::SLOTS-1:0] w_res_q;

    logic                   r_s1_vld;
    logic [AW-1:0]          r_s1_addr;
    logic                   r_s1_inr;
    logic                   r_s1_shift;
    hrta_pkg::t_key_set     r_s1_keys;

    // input decode
    assign w_kb_ext  = (AW+3)'(i_s_tuser);
    assign w_in_keys = i_s_tdata[55:8];
    assign w_accept  = i_s_tvalid && o_s_tready;

    // lookup stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_addr  <= w_kb_ext[AW-1:0];
            r_s1_inr   <= (w_kb_ext < (AW+3)'(KEYBOARDS));
            r_s1_shift <= ((i_s_tdata[7:0] & hrta_pkg::SHIFT_MASK) != '0);
            r_s1_keys  <= w_in_keys;
        end
    end

    // previous key sets
    hrta_key_store #(
        .KEYBOARDS (KEYBOARDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_kb_ext[AW-1:0]),
        .o_rd_keys (w_prev),
        .i_wr_en   (w_s1_adv && r_s1_inr),
        .i_wr_addr (r_s1_addr),
        .i_wr_keys (r_s1_keys)
    );

    // one lane per key slot
    for (genvar g = 0; g < hrta_pkg::SLOTS; g++) begin : g_lane
        hrta_lane u_lane (
            .i_key     (r_s1_keys[g]),
            .i_prev    (w_prev),
            .i_shifted (r_s1_shift),
            .o_res     (w_res[g])
        );
        // a keyboard out of range yields nothing
        assign w_res_q[g].hit = w_res[g].hit && r_s1_inr;
        assign w_res_q[g].chr = w_res[g].chr;
    end

    always_comb begin
        w_any_hit = 1'b0;
        for (int i = 0; i < hrta_pkg::SLOTS; i++) begin
            w_any_hit = w_any_hit | w_res_q[i].hit;
        end
    end

    // advance when nothing to send or the merge stage frees up
    assign w_s1_adv   = r_s1_vld && (!w_any_hit || w_can_load);
    assign w_load     = w_s1_adv && w_any_hit;
    assign o_s_tready = !r_s1_vld || w_s1_adv;

    hrta_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_res      (w_res_q),
        .o_can_load (w_can_load),
        .o_tvalid   (o_m_tvalid),
        .i_tready   (i_m_tready),
        .o_chr      (w_chr),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_chr};

    // checks
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_can_load)
        else $error("merge stage loaded while still busy");

    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_vld)
        else $error("accepted report lost before lookup stage");

    a_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_chr != '0))
        else $error("zero character sent");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast && !w_load) |=> !o_m_tvalid)
        else $error("words remain after last of report");

endmodule

// File: tb/tb_hid_boot_report_to_ascii.sv
// ----------------------------------------------------------------------------
// tb_hid_boot_report_to_ascii
// Self-checking bench for the boot report to ASCII converter. Reports go in
// through a stream driver fed from a queue, and a shadow decoder with its own
// per-keyboard held-key sets predicts the characters. A monitor checks every
// output word in order. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hid_boot_report_to_ascii;

    localparam int NUM_KBD      = 8;
    localparam int CLK_PERIOD   = 12;
    localparam int RST_CYCLES   = 9;
    localparam int RAND_REPORTS = 92;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_WAIT     = 11;

    // keycodes 30 .. 56: digit row and punctuation, zero where unmapped
    localparam logic [hrta_pkg::CHAR_W-1:0] ROW_PLAIN [0:26] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h2d, 7'h3d, 7'h5b, 7'h5d, 7'h5c,
        7'h00, 7'h3b, 7'h27, 7'h60, 7'h2c, 7'h2e, 7'h2f
    };
    localparam logic [hrta_pkg::CHAR_W-1:0] ROW_SHIFT [0:26] = '{
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
        7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h5f, 7'h2b, 7'h7b, 7'h7d, 7'h7c,
        7'h00, 7'h3a, 7'h22, 7'h7e, 7'h3c, 7'h3e, 7'h3f
    };

    localparam logic [hrta_pkg::KEY_W-1:0] MOD_NONE   = 8'h00;
    localparam logic [hrta_pkg::KEY_W-1:0] MOD_LSHIFT = 8'h02;
    localparam logic [hrta_pkg::KEY_W-1:0] MOD_RSHIFT = 8'h20;
    localparam logic [hrta_pkg::KEY_W-1:0] MOD_BOTH   = 8'h22;

    typedef struct {
        logic [2:0]                 kbd;
        logic [hrta_pkg::KEY_W-1:0] mods;
        hrta_pkg::t_key_set         keys;
    } t_report;

    typedef struct {
        logic [hrta_pkg::CHAR_W-1:0] chr;
        logic                        last;
    } t_typed_char;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    t_report            report_q [$];
    t_typed_char        char_q [$];
    hrta_pkg::t_key_set held_keys [NUM_KBD];
    t_report            cur_rep;
    int          accepted_cnt = 0;
    int          total_reports = 0;
    int          err_cnt = 0;
    int          tx_gap = 0;
    int          rx_wait = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    hid_boot_report_to_ascii #(
        .KEYBOARDS (NUM_KBD)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // us layout lookup, zero for unmapped or out of table
    function automatic logic [hrta_pkg::CHAR_W-1:0] key_char(logic [hrta_pkg::KEY_W-1:0] kc,
                                                             logic shifted);
        if (kc >= 8'd4 && kc <= 8'd29) begin
            return hrta_pkg::CHAR_W'((shifted ? 8'h41 : 8'h61) + (kc - 8'd4));
        end else if (kc >= 8'd30 && kc < hrta_pkg::KEY_W'(hrta_pkg::TABLE_LEN)) begin
            return shifted ? ROW_SHIFT[5'(kc - 8'd30)] : ROW_PLAIN[5'(kc - 8'd30)];
        end
        return '0;
    endfunction

    // new presses of one report become expected characters, then the set is kept
    function automatic void decode_report(t_report r);
        logic                        shifted;
        logic                        held;
        logic [hrta_pkg::CHAR_W-1:0] c;
        logic [hrta_pkg::CHAR_W-1:0] hits [hrta_pkg::SLOTS];
        int                          n;
        n = 0;
        if (r.kbd >= NUM_KBD) return;
        shifted = (r.mods & hrta_pkg::SHIFT_MASK) != '0;
        for (int i = 0; i < hrta_pkg::SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < hrta_pkg::SLOTS; j++) begin
                if (held_keys[r.kbd][j] == r.keys[i]) held = 1'b1;
            end
            c = key_char(r.keys[i], shifted);
            if (r.keys[i] != '0 && !held && c != '0) begin
                hits[n] = c;
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            char_q.push_back('{chr: hits[i], last: (i == n - 1)});
        end
        for (int i = 0; i < hrta_pkg::SLOTS; i++) held_keys[r.kbd][i] = r.keys[i];
    endfunction

    function automatic hrta_pkg::t_key_set key_set(logic [7:0] k0, logic [7:0] k1,
                                                   logic [7:0] k2, logic [7:0] k3,
                                                   logic [7:0] k4, logic [7:0] k5);
        return {k5, k4, k3, k2, k1, k0};
    endfunction

    task automatic add_report(logic [2:0] kbd, logic [hrta_pkg::KEY_W-1:0] mods,
                              hrta_pkg::t_key_set keys);
        report_q.push_back('{kbd: kbd, mods: mods, keys: keys});
        total_reports++;
    endtask

    task automatic report_err(string what, int exp_v, int got_v);
        $display("%0t ns  mismatch: %s  expected %0h  got %0h", $time, what, exp_v, got_v);
        err_cnt++;
    endtask

    // report driver, random gap before each word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            for (int k = 0; k < NUM_KBD; k++) held_keys[k] = '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                decode_report(cur_rep);
                accepted_cnt++;
                if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (report_q.size() != 0) begin
                cur_rep = report_q.pop_front();
                s_tdata  <= {cur_rep.keys, cur_rep.mods};
                s_tuser  <= cur_rep.kbd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // character monitor, random stall after each word
    always @(posedge i_clk) begin
        t_typed_char want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (char_q.size() == 0) begin
                    report_err("word with no character pending", 0, m_tdata);
                end else begin
                    want = char_q.pop_front();
                    if (m_tdata[hrta_pkg::CHAR_W-1:0] != want.chr)
                        report_err("ascii_char", want.chr, m_tdata[hrta_pkg::CHAR_W-1:0]);
                    if (m_tdata[7] !== 1'b0)
                        report_err("tdata pad bit", 0, m_tdata[7]);
                    if (m_tlast !== want.last)
                        report_err("last_of_report", want.last, m_tlast);
                end
                if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stim
        hrta_pkg::t_key_set         gen_prev [NUM_KBD];
        hrta_pkg::t_key_set         ks;
        logic [2:0]                 kb;
        logic [hrta_pkg::KEY_W-1:0] mods;
        logic [hrta_pkg::KEY_W-1:0] kc;
        int                         cnt;
        int                         pick;

        for (int k = 0; k < NUM_KBD; k++) gen_prev[k] = '0;

        // letters, six new keys at once
        add_report(3'd0, MOD_NONE, key_set(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        // same keys still held
        add_report(3'd0, MOD_NONE, key_set(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        // all released
        add_report(3'd0, MOD_NONE, '0);
        // shifted digit row, left shift
        add_report(3'd0, MOD_LSHIFT, key_set(8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23));
        // rest of digits and symbols, right shift
        add_report(3'd1, MOD_RSHIFT, key_set(8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e));
        // non-shift modifier bits only, enter / unmapped / backspace / tab / space
        add_report(3'd2, 8'hdd, key_set(8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d));
        // every modifier bit, brackets and the unmapped hole
        add_report(3'd3, 8'hff, key_set(8'h2e, 8'h2f, 8'h30, 8'h31, 8'h32, 8'h33));
        // top of the table and first key past it
        add_report(3'd4, MOD_NONE, key_set(8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39));
        add_report(3'd4, MOD_BOTH, key_set(8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39));
        // nothing printable, still stored
        add_report(3'd5, MOD_NONE, key_set(8'hff, 8'h80, 8'h39, 8'h3a, 8'h01, 8'h02));
        add_report(3'd5, MOD_NONE, key_set(8'hff, 8'h04, 8'h00, 8'h03, 8'h00, 8'h80));
        // one key repeated in a report
        add_report(3'd6, MOD_NONE, key_set(8'h05, 8'h05, 8'h05, 8'h00, 8'h00, 8'h00));
        add_report(3'd6, MOD_LSHIFT, key_set(8'h05, 8'h06, 8'h05, 8'h06, 8'h00, 8'h00));
        // keyboards keep separate sets
        add_report(3'd7, MOD_NONE, key_set(8'h29, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00));
        add_report(3'd1, MOD_NONE, key_set(8'h04, 8'h24, 8'h00, 8'h00, 8'h00, 8'h00));
        add_report(3'd7, MOD_RSHIFT, key_set(8'h1d, 8'h1d, 8'h29, 8'h00, 8'h00, 8'h1c));
        // only the last slot
        add_report(3'd2, MOD_NONE, key_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1d));
        add_report(3'd0, MOD_NONE, key_set(8'haa, 8'h55, 8'h7f, 8'h00, 8'h38, 8'h04));

        // directed reports change state, seed the generator's view of keyboard 0's set
        gen_prev[0] = key_set(8'haa, 8'h55, 8'h7f, 8'h00, 8'h38, 8'h04);

        // typing-like sequences, mostly held keys plus new presses, some noise
        for (int n = 0; n < RAND_REPORTS; n++) begin
            kb = 3'($urandom_range(0, NUM_KBD - 1));
            if ($urandom_range(0, 9) == 0) begin
                mods = 8'($urandom);
                ks   = {16'($urandom), 32'($urandom)};
            end else begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0:       mods = 8'($urandom);
                    1:       mods = MOD_LSHIFT;
                    2:       mods = MOD_RSHIFT;
                    default: mods = MOD_NONE;
                endcase
                ks  = '0;
                cnt = $urandom_range(0, hrta_pkg::SLOTS);
                for (int i = 0; i < cnt; i++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)      kc = gen_prev[kb][$urandom_range(0, hrta_pkg::SLOTS - 1)];
                    else if (pick < 9) kc = 8'($urandom_range(4, hrta_pkg::TABLE_LEN - 1));
                    else               kc = 8'($urandom);
                    ks[$urandom_range(0, hrta_pkg::SLOTS - 1)] = kc;
                end
            end
            gen_prev[kb] = ks;
            add_report(kb, mods, ks);
        end

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_reports) @(posedge i_clk);
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #(2_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
